@@ design/tsd_pkg.sv @@
package tsd_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int FRAME_W  = 9;
    localparam int PIX_W    = 8;
    localparam int RAD_W    = 4;
    localparam int ACT_W    = 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPLY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] REG_WALL_THR = 2'd0;
    localparam logic [1:0] REG_RADIUS   = 2'd1;
    localparam logic [1:0] REG_ROWS     = 2'd2;
    localparam logic [1:0] REG_COLS     = 2'd3;

    localparam logic [PIX_W-1:0]   RST_WALL_THR = 8'd80;
    localparam logic [RAD_W-1:0]   RST_RADIUS   = 4'd7;
    localparam logic [FRAME_W-1:0] RST_ROWS     = 9'd256;
    localparam logic [FRAME_W-1:0] RST_COLS     = 9'd256;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_APPLY,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [ROW_W-1:0]    row_lo;
        logic [ROW_W-1:0]    row_hi;
        logic [COL_W-1:0]    col;
        logic                in_frame;
        logic [MAX_COLS-1:0] mask;
    } t_cmd_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_APPLY,
        BK_READ
    } t_back_state;

endpackage

@@ design/tsd_front.sv @@
module tsd_front (
    input  logic                         i_in_valid,
    input  logic [tsd_pkg::ACT_W-1:0]    i_action,
    input  logic [tsd_pkg::ROW_W-1:0]    i_row_index,
    input  logic [tsd_pkg::COL_W-1:0]    i_col_index,
    input  logic [tsd_pkg::PIX_W-1:0]    i_pixel_value,
    input  logic [tsd_pkg::PIX_W-1:0]    i_wall_thr,
    input  logic [tsd_pkg::RAD_W-1:0]    i_radius,
    input  logic [tsd_pkg::FRAME_W-1:0]  i_frame_rows,
    input  logic [tsd_pkg::FRAME_W-1:0]  i_frame_cols,
    input  tsd_pkg::t_q_status           i_q_status,
    output logic                         o_in_stall,
    output logic                         o_push,
    output tsd_pkg::t_cmd_item           o_cmd
);

    logic [tsd_pkg::FRAME_W-1:0]  eff_rows;
    logic [tsd_pkg::FRAME_W-1:0]  eff_cols;
    logic [tsd_pkg::FRAME_W-1:0]  row9;
    logic [tsd_pkg::FRAME_W-1:0]  col9;
    logic [tsd_pkg::FRAME_W-1:0]  rad9;
    logic [tsd_pkg::FRAME_W-1:0]  row_hi9;
    logic [tsd_pkg::FRAME_W-1:0]  col_hi9;
    logic [tsd_pkg::FRAME_W-1:0]  row_lim;
    logic [tsd_pkg::FRAME_W-1:0]  col_lim;
    logic [tsd_pkg::ROW_W-1:0]    row_lo;
    logic [tsd_pkg::ROW_W-1:0]    row_hi;
    logic [tsd_pkg::COL_W-1:0]    col_lo;
    logic [tsd_pkg::COL_W-1:0]    col_hi;
    logic                         in_frame;
    logic                         accept;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;

    always_comb begin
        eff_rows = (i_frame_rows < tsd_pkg::FRAME_W'(tsd_pkg::MAX_ROWS)) ?
                   i_frame_rows : tsd_pkg::FRAME_W'(tsd_pkg::MAX_ROWS);
        eff_cols = (i_frame_cols < tsd_pkg::FRAME_W'(tsd_pkg::MAX_COLS)) ?
                   i_frame_cols : tsd_pkg::FRAME_W'(tsd_pkg::MAX_COLS);
        row9     = tsd_pkg::FRAME_W'(i_row_index);
        col9     = tsd_pkg::FRAME_W'(i_col_index);
        rad9     = tsd_pkg::FRAME_W'(i_radius);
        in_frame = (row9 < eff_rows) && (col9 < eff_cols);

        row_lim  = eff_rows - 1'b1;
        col_lim  = eff_cols - 1'b1;
        row_hi9  = row9 + rad9;
        col_hi9  = col9 + rad9;
        row_lo   = (row9 >= rad9) ? tsd_pkg::ROW_W'(row9 - rad9) : '0;
        col_lo   = (col9 >= rad9) ? tsd_pkg::COL_W'(col9 - rad9) : '0;
        row_hi   = (row_hi9 > row_lim) ? tsd_pkg::ROW_W'(row_lim) : tsd_pkg::ROW_W'(row_hi9);
        col_hi   = (col_hi9 > col_lim) ? tsd_pkg::COL_W'(col_lim) : tsd_pkg::COL_W'(col_hi9);

        o_cmd.row_lo   = row_lo;
        o_cmd.row_hi   = row_hi;
        o_cmd.col      = i_col_index;
        o_cmd.in_frame = in_frame;
        o_cmd.mask     = ({tsd_pkg::MAX_COLS{1'b1}} << col_lo) &
                         ({tsd_pkg::MAX_COLS{1'b1}} >>
                          (tsd_pkg::COL_W'(tsd_pkg::MAX_COLS - 1) - col_hi));
        o_cmd.kind     = tsd_pkg::CMD_CLEAR;
        o_push         = 1'b0;

        unique case (i_action)
            tsd_pkg::ACT_CLEAR: begin
                o_cmd.kind = tsd_pkg::CMD_CLEAR;
                o_push     = accept;
            end
            tsd_pkg::ACT_APPLY: begin
                o_cmd.kind = tsd_pkg::CMD_APPLY;
                o_push     = accept && in_frame && (i_pixel_value > i_wall_thr);
            end
            tsd_pkg::ACT_READ: begin
                o_cmd.row_lo = i_row_index;
                o_cmd.kind   = tsd_pkg::CMD_READ;
                o_push       = accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

@@ design/tsd_queue.sv @@
module tsd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tsd_pkg::t_cmd_item    i_data,
    input  logic                  i_pop,
    output tsd_pkg::t_cmd_item    o_head,
    output tsd_pkg::t_q_status    o_status
);

    tsd_pkg::t_cmd_item             r_slot [tsd_pkg::Q_DEPTH];
    logic [tsd_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [tsd_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [tsd_pkg::Q_CNT_W-1:0]    r_count;
    logic [tsd_pkg::Q_PTR_W-1:0]    n_wr_ptr;
    logic [tsd_pkg::Q_PTR_W-1:0]    n_rd_ptr;
    logic [tsd_pkg::Q_CNT_W-1:0]    n_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_status.full  = (r_count == tsd_pkg::Q_CNT_W'(tsd_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_slot[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == tsd_pkg::Q_PTR_W'(tsd_pkg::Q_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == tsd_pkg::Q_PTR_W'(tsd_pkg::Q_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ design/tsd_back.sv @@
module tsd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tsd_pkg::t_cmd_item    i_head,
    input  tsd_pkg::t_q_status    i_q_status,
    output logic                  o_pop,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_cell_marked
);

    logic [tsd_pkg::MAX_COLS-1:0]  mem [tsd_pkg::MAX_ROWS];

    tsd_pkg::t_back_state          r_state;
    tsd_pkg::t_back_state          n_state;
    logic [tsd_pkg::MAX_ROWS-1:0]  r_row_valid;
    logic [tsd_pkg::MAX_ROWS-1:0]  n_row_valid;
    logic [tsd_pkg::ROW_W-1:0]     r_wr_row;
    logic [tsd_pkg::ROW_W-1:0]     n_wr_row;
    logic [tsd_pkg::ROW_W-1:0]     r_last;
    logic [tsd_pkg::ROW_W-1:0]     n_last;
    logic [tsd_pkg::MAX_COLS-1:0]  r_mask;
    logic [tsd_pkg::MAX_COLS-1:0]  n_mask;
    logic [tsd_pkg::COL_W-1:0]     r_rd_col;
    logic [tsd_pkg::COL_W-1:0]     n_rd_col;
    logic                          r_in_frame;
    logic                          n_in_frame;
    logic [tsd_pkg::MAX_COLS-1:0]  r_rd_data;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic                          r_cell_marked;
    logic                          n_cell_marked;
    logic                          rd_en;
    logic [tsd_pkg::ROW_W-1:0]     rd_addr;
    logic                          wr_en;
    logic [tsd_pkg::MAX_COLS-1:0]  wr_data;
    logic                          out_take;

    assign o_out_valid   = r_out_valid;
    assign o_cell_marked = r_cell_marked;
    assign out_take      = r_out_valid && !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_row_valid   = r_row_valid;
        n_wr_row      = r_wr_row;
        n_last        = r_last;
        n_mask        = r_mask;
        n_rd_col      = r_rd_col;
        n_in_frame    = r_in_frame;
        n_out_valid   = r_out_valid && i_out_stall;
        n_cell_marked = r_cell_marked;
        o_pop         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = r_wr_row;
        wr_en         = 1'b0;
        wr_data       = (r_row_valid[r_wr_row] ? r_rd_data : '0) | r_mask;

        unique case (r_state)
            tsd_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    unique case (i_head.kind)
                        tsd_pkg::CMD_CLEAR: begin
                            o_pop       = 1'b1;
                            n_row_valid = '0;
                        end
                        tsd_pkg::CMD_APPLY: begin
                            o_pop    = 1'b1;
                            rd_en    = 1'b1;
                            rd_addr  = i_head.row_lo;
                            n_wr_row = i_head.row_lo;
                            n_last   = i_head.row_hi;
                            n_mask   = i_head.mask;
                            n_state  = tsd_pkg::BK_APPLY;
                        end
                        tsd_pkg::CMD_READ: begin
                            if (!r_out_valid || out_take) begin
                                o_pop      = 1'b1;
                                rd_en      = 1'b1;
                                rd_addr    = i_head.row_lo;
                                n_wr_row   = i_head.row_lo;
                                n_rd_col   = i_head.col;
                                n_in_frame = i_head.in_frame;
                                n_state    = tsd_pkg::BK_READ;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            tsd_pkg::BK_APPLY: begin
                wr_en                 = 1'b1;
                n_row_valid[r_wr_row] = 1'b1;
                if (r_wr_row == r_last) begin
                    n_state = tsd_pkg::BK_IDLE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = r_wr_row + 1'b1;
                    n_wr_row = r_wr_row + 1'b1;
                end
            end
            tsd_pkg::BK_READ: begin
                n_out_valid   = 1'b1;
                n_cell_marked = r_in_frame && r_row_valid[r_wr_row] && r_rd_data[r_rd_col];
                n_state       = tsd_pkg::BK_IDLE;
            end
            default: begin
                n_state = tsd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsd_pkg::BK_IDLE;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_row      <= n_wr_row;
        r_last        <= n_last;
        r_mask        <= n_mask;
        r_rd_col      <= n_rd_col;
        r_in_frame    <= n_in_frame;
        r_cell_marked <= n_cell_marked;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[r_wr_row] <= wr_data;
        end
    end

endmodule

@@ design/threshold_square_dilation_core.sv @@
// Channel   Valid        Stall         Payload
// input     i_in_valid   o_in_stall    i_action, i_row_index, i_col_index, i_pixel_value
// output    o_out_valid  i_out_stall   o_cell_marked
// config    psel/penable pready (=1)   paddr, pwdata, pwrite, prdata
//
// Apply of a wall pixel: the back end steps through the clipped window rows (up
// to 2*radius+1), one row read-modify-write per cycle on the map RAM.
// Clear drops the row valid flops. Read passes through the RAM read and BK_READ.
// Items that do nothing are taken by the front end without entering the queue.
// Reset is synchronous: queue, back-end state, output and all row valid bits clear.
// A stalled output holds the read result and the back end waits on further reads.
module threshold_square_dilation_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tsd_pkg::ACT_W-1:0]     i_action,
    input  logic [tsd_pkg::ROW_W-1:0]     i_row_index,
    input  logic [tsd_pkg::COL_W-1:0]     i_col_index,
    input  logic [tsd_pkg::PIX_W-1:0]     i_pixel_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_cell_marked,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsd_pkg::ADDR_W-1:0]    paddr,
    input  logic [tsd_pkg::DATA_W-1:0]    pwdata,
    output logic [tsd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [tsd_pkg::PIX_W-1:0]    r_wall_thr;
    logic [tsd_pkg::RAD_W-1:0]    r_radius;
    logic [tsd_pkg::FRAME_W-1:0]  r_frame_rows;
    logic [tsd_pkg::FRAME_W-1:0]  r_frame_cols;
    logic                         cfg_wr;
    logic                         q_push;
    logic                         q_pop;
    tsd_pkg::t_cmd_item           q_in;
    tsd_pkg::t_cmd_item           q_head;
    tsd_pkg::t_q_status           q_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_thr   <= tsd_pkg::RST_WALL_THR;
            r_radius     <= tsd_pkg::RST_RADIUS;
            r_frame_rows <= tsd_pkg::RST_ROWS;
            r_frame_cols <= tsd_pkg::RST_COLS;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                tsd_pkg::REG_WALL_THR: r_wall_thr   <= pwdata[tsd_pkg::PIX_W-1:0];
                tsd_pkg::REG_RADIUS:   r_radius     <= pwdata[tsd_pkg::RAD_W-1:0];
                tsd_pkg::REG_ROWS:     r_frame_rows <= pwdata[tsd_pkg::FRAME_W-1:0];
                tsd_pkg::REG_COLS:     r_frame_cols <= pwdata[tsd_pkg::FRAME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tsd_pkg::REG_WALL_THR: prdata = tsd_pkg::DATA_W'(r_wall_thr);
            tsd_pkg::REG_RADIUS:   prdata = tsd_pkg::DATA_W'(r_radius);
            tsd_pkg::REG_ROWS:     prdata = tsd_pkg::DATA_W'(r_frame_rows);
            tsd_pkg::REG_COLS:     prdata = tsd_pkg::DATA_W'(r_frame_cols);
            default:               prdata = '0;
        endcase
    end

    tsd_front u_front (
        .i_in_valid    (i_in_valid),
        .i_action      (i_action),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_pixel_value (i_pixel_value),
        .i_wall_thr    (r_wall_thr),
        .i_radius      (r_radius),
        .i_frame_rows  (r_frame_rows),
        .i_frame_cols  (r_frame_cols),
        .i_q_status    (q_status),
        .o_in_stall    (o_in_stall),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    tsd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_in),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    tsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_q_status    (q_status),
        .o_pop         (q_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_cell_marked (o_cell_marked)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("queue push while full");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue pop while empty");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> q_status.empty && !o_out_valid)
        else $error("queue or output not cleared by reset");

    a_push_when_idle_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> i_in_valid && !o_in_stall)
        else $error("queue push without an accepted transaction");
`endif

endmodule

@@ sim/threshold_square_dilation_checker.sv @@
`timescale 1ns / 1ps

module threshold_square_dilation_checker
    import tsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ROW_W-1:0]  i_row_index,
    input  logic [COL_W-1:0]  i_col_index,
    input  logic [PIX_W-1:0]  i_pixel_value,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_cell_marked,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    input  logic              i_final_check,
    output int                o_fail_count,
    output int                o_reads_pending,
    output int                o_reads_checked,
    output int                o_marked_seen
);

    logic [MAX_COLS-1:0] mark_map [MAX_ROWS];
    logic [PIX_W-1:0]    wall_thr_q;
    logic [RAD_W-1:0]    radius_q;
    logic [FRAME_W-1:0]  rows_q;
    logic [FRAME_W-1:0]  cols_q;
    bit                  expected_marks [$];
    bit                  mark_wanted;
    bit                  leftovers_done;

    function automatic int frame_limit(input logic [FRAME_W-1:0] size, input int max_size);
        return (int'(size) < max_size) ? int'(size) : max_size;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic queue_read_result(input bit mark);
        expected_marks.insert(expected_marks.size(), mark);
    endtask

    task automatic paint_window(input int row, input int col, input int pix);
        int nr, nc, rad, r0, r1, c0, c1;
        nr  = frame_limit(rows_q, MAX_ROWS);
        nc  = frame_limit(cols_q, MAX_COLS);
        rad = int'(radius_q);
        if (row >= nr || col >= nc || pix <= int'(wall_thr_q)) begin
            return;
        end
        r0 = (row - rad < 0) ? 0 : row - rad;
        c0 = (col - rad < 0) ? 0 : col - rad;
        r1 = (row + rad > nr - 1) ? nr - 1 : row + rad;
        c1 = (col + rad > nc - 1) ? nc - 1 : col + rad;
        for (int r = r0; r <= r1; r++) begin
            for (int c = c0; c <= c1; c++) begin
                mark_map[r][c] = 1'b1;
            end
        end
    endtask

    function automatic bit cell_lit(input int row, input int col);
        if (row >= frame_limit(rows_q, MAX_ROWS) || col >= frame_limit(cols_q, MAX_COLS)) begin
            return 1'b0;
        end
        return mark_map[row][col];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (mark_map[r]) mark_map[r] = '0;
            wall_thr_q = RST_WALL_THR;
            radius_q   = RST_RADIUS;
            rows_q     = RST_ROWS;
            cols_q     = RST_COLS;
            expected_marks.delete();
            leftovers_done  = 1'b0;
            o_fail_count    = 0;
            o_reads_checked = 0;
            o_marked_seen   = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_marks.size() == 0) begin
                    report_mismatch($sformatf("result cell_marked=%0b with no read pending",
                                              i_cell_marked));
                end else begin
                    mark_wanted = expected_marks.pop_front();
                    if (i_cell_marked !== mark_wanted) begin
                        report_mismatch($sformatf("cell_marked got %0b want %0b",
                                                  i_cell_marked, mark_wanted));
                    end
                    o_reads_checked++;
                    if (mark_wanted) o_marked_seen++;
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_WALL_THR: wall_thr_q = i_pwdata[PIX_W-1:0];
                    REG_RADIUS:   radius_q   = i_pwdata[RAD_W-1:0];
                    REG_ROWS:     rows_q     = i_pwdata[FRAME_W-1:0];
                    REG_COLS:     cols_q     = i_pwdata[FRAME_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_action)
                    ACT_CLEAR: foreach (mark_map[r]) mark_map[r] = '0;
                    ACT_APPLY: paint_window(i_row_index, i_col_index, i_pixel_value);
                    ACT_READ:  queue_read_result(cell_lit(i_row_index, i_col_index));
                    default: ;
                endcase
            end
            if (i_final_check && !leftovers_done) begin
                leftovers_done = 1'b1;
                while (expected_marks.size() != 0) begin
                    mark_wanted = expected_marks.pop_front();
                    report_mismatch($sformatf("read result %0b never arrived", mark_wanted));
                end
            end
        end
        o_reads_pending = expected_marks.size();
    end

endmodule

@@ sim/tb_threshold_square_dilation_core.sv @@
`timescale 1ns / 1ps

module tb_threshold_square_dilation_core;
    import tsd_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 120;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int BURST_READS   = 40;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int IDLE_NONE    = 0;
    localparam int IDLE_SENDER  = 1;
    localparam int IDLE_STALL   = 2;
    localparam int IDLE_BOTH    = 3;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [ACT_W-1:0]  i_action;
    logic [ROW_W-1:0]  i_row_index;
    logic [COL_W-1:0]  i_col_index;
    logic [PIX_W-1:0]  i_pixel_value;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_cell_marked;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              final_check;

    int fail_count;
    int reads_pending;
    int reads_checked;
    int marked_seen;

    int  idle_pct;
    int  stall_pct;
    bit  hold_off_on;
    int  cycle_count;
    int  cur_thr;
    int  cur_rad;
    int  cur_rows;
    int  cur_cols;
    int  last_row;
    int  last_col;
    int  settings_used;
    int  n_apply;
    int  n_read;
    int  n_clear;
    int  n_unused;

    threshold_square_dilation_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cell_marked (o_cell_marked),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    threshold_square_dilation_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_pixel_value   (i_pixel_value),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_cell_marked   (o_cell_marked),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_final_check   (final_check),
        .o_fail_count    (fail_count),
        .o_reads_pending (reads_pending),
        .o_reads_checked (reads_checked),
        .o_marked_seen   (marked_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_threshold_square_dilation_core: FAIL");
        $finish;
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= hold_off_on || ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic int clamp_byte(input int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            IDLE_NONE:   begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER: begin idle_pct = 61; stall_pct = 0;  end
            IDLE_STALL:  begin idle_pct = 0;  stall_pct = 61; end
            default:     begin idle_pct = 13; stall_pct = 13; end
        endcase
    endtask

    task automatic hold_output(input int cycles);
        fork
            begin
                hold_off_on = 1'b1;
                repeat (cycles) @(negedge i_clk);
                hold_off_on = 1'b0;
            end
        join_none
    endtask

    task automatic send_item(input logic [ACT_W-1:0] act, input int row, input int col,
                             input int pix);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_row_index   <= row[ROW_W-1:0];
        i_col_index   <= col[COL_W-1:0];
        i_pixel_value <= pix[PIX_W-1:0];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        case (act)
            ACT_CLEAR: n_clear++;
            ACT_APPLY: n_apply++;
            ACT_READ:  n_read++;
            default:   n_unused++;
        endcase
    endtask

    // drop valid, wait for every read result, then let a pending apply finish
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (reads_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WALL_THR: cur_thr  = value & 'hFF;
            REG_RADIUS:   cur_rad  = value & 'hF;
            REG_ROWS:     cur_rows = value & 'h1FF;
            default:      cur_cols = value & 'h1FF;
        endcase
    endtask

    task automatic random_transaction(output bit counted);
        int roll, er, ec, row, col, pix, span;
        logic [ACT_W-1:0] act;
        roll    = $urandom_range(0, 99);
        er      = (cur_rows > MAX_ROWS) ? MAX_ROWS : cur_rows;
        ec      = (cur_cols > MAX_COLS) ? MAX_COLS : cur_cols;
        counted = 1'b1;
        pix     = $urandom_range(0, 255);
        if ($urandom_range(0, 9) < 3) begin
            row = $urandom_range(0, 255);
            col = $urandom_range(0, 255);
        end else begin
            row = $urandom_range(0, clamp_byte(er + 3));
            col = $urandom_range(0, clamp_byte(ec + 3));
        end
        if (roll < 2) begin
            act = ACT_CLEAR;
        end else if (roll < 4) begin
            act     = ACT_UNUSED;
            counted = 1'b0;
        end else if (roll < 50) begin
            act = ACT_APPLY;
            if ($urandom_range(0, 1) == 1) begin
                pix = clamp_byte(cur_thr + int'($urandom_range(0, 4)) - 2);
            end
            if (pix > cur_thr) begin
                last_row = row;
                last_col = col;
            end
        end else begin
            act = ACT_READ;
            if ($urandom_range(0, 9) < 6) begin
                span = cur_rad + 2;
                row  = clamp_byte(last_row + int'($urandom_range(0, 2 * span)) - span);
                col  = clamp_byte(last_col + int'($urandom_range(0, 2 * span)) - span);
            end
        end
        send_item(act, row, col, pix);
    endtask

    task automatic run_phase(input int thr, input int rad, input int rows, input int cols,
                             input int mode, input int items);
        int  done;
        bit  counted;
        settle();
        write_reg(REG_WALL_THR, thr);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
        settings_used++;
        set_idling(mode);
        done = 0;
        while (done < items) begin
            random_transaction(counted);
            if (counted) done++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = ACT_CLEAR;
        i_row_index   = '0;
        i_col_index   = '0;
        i_pixel_value = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        final_check   = 1'b0;
        hold_off_on   = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        cur_thr       = RST_WALL_THR;
        cur_rad       = RST_RADIUS;
        cur_rows      = RST_ROWS;
        cur_cols      = RST_COLS;
        last_row      = 0;
        last_col      = 0;
        settings_used = 1;
        n_apply       = 0;
        n_read        = 0;
        n_clear       = 0;
        n_unused      = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(ACT_READ,   0,   0,   0);
        send_item(ACT_APPLY,  0,   0,   255);
        send_item(ACT_READ,   7,   7,   0);
        send_item(ACT_READ,   8,   0,   0);
        send_item(ACT_APPLY,  255, 255, 81);
        send_item(ACT_READ,   255, 248, 0);
        send_item(ACT_READ,   247, 255, 0);
        send_item(ACT_APPLY,  128, 128, 80);
        send_item(ACT_READ,   128, 128, 0);
        send_item(ACT_UNUSED, 128, 128, 255);
        send_item(ACT_READ,   128, 128, 0);
        send_item(ACT_CLEAR,  0,   0,   0);
        send_item(ACT_READ,   0,   0,   0);
        send_item(ACT_READ,   255, 255, 0);
        settle();
        write_reg(REG_RADIUS, 0);
        write_reg(REG_ROWS, 100);
        write_reg(REG_COLS, 100);
        send_item(ACT_APPLY,  50,  50,  200);
        send_item(ACT_READ,   50,  50,  0);
        send_item(ACT_READ,   50,  51,  0);
        send_item(ACT_APPLY,  150, 20,  255);
        send_item(ACT_APPLY,  90,  90,  255);
        settle();
        write_reg(REG_ROWS, 50);
        send_item(ACT_READ,   90,  90,  0);
        settle();
        write_reg(REG_ROWS, 0);
        send_item(ACT_READ,   10,  10,  0);
        settle();
        write_reg(REG_ROWS, 256);
        write_reg(REG_COLS, 256);
        send_item(ACT_READ,   90,  90,  0);
        send_item(ACT_READ,   150, 20,  0);

        run_phase(80, 7, 256, 256, IDLE_NONE, PHASE_ITEMS);
        // hold the output while reads keep coming, so the input backs up
        set_idling(IDLE_NONE);
        hold_output(HOLD_CYCLES);
        repeat (BURST_READS) begin
            send_item(ACT_READ, clamp_byte(last_row + int'($urandom_range(0, 4)) - 2),
                      clamp_byte(last_col + int'($urandom_range(0, 4)) - 2), 0);
        end
        run_phase(0, 0, 256, 256, IDLE_SENDER, PHASE_ITEMS);
        run_phase(255, 15, 256, 256, IDLE_STALL, PHASE_ITEMS);
        run_phase(128, 15, 40, 200, IDLE_BOTH, PHASE_ITEMS);
        run_phase(10, 3, 1, 1, IDLE_NONE, PHASE_ITEMS);
        run_phase($urandom_range(0, 255), $urandom_range(0, 15), 256, 17, IDLE_SENDER,
                  PHASE_ITEMS);
        run_phase(60, 15, 300, 511, IDLE_STALL, PHASE_ITEMS);
        run_phase($urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(1, 256),
                  $urandom_range(1, 256), IDLE_BOTH, PHASE_ITEMS);

        settle();
        @(negedge i_clk);
        final_check <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("covered %0d applies, %0d reads (%0d checked, %0d marked), %0d clears, %0d unused",
                 n_apply, n_read, reads_checked, marked_seen, n_clear, n_unused);
        $display("across %0d register settings and four handshake idling modes in %0d cycles",
                 settings_used, cycle_count);
        if (fail_count == 0) begin
            $display("tb_threshold_square_dilation_core: PASS");
        end else begin
            $display("tb_threshold_square_dilation_core: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/tsd_pkg.sv
design/tsd_front.sv
design/tsd_queue.sv
design/tsd_back.sv
design/threshold_square_dilation_core.sv
sim/threshold_square_dilation_checker.sv
sim/tb_threshold_square_dilation_core.sv
